>>> rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FPFL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define FPFL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define FPFL_ASSERT(label, prop, msg)

`define FPFL_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> rtl/fpfl_pkg.sv
package fpfl_pkg;

   localparam int KIND_W    = 2;
   localparam int INDEX_W   = 8;
   localparam int PROBE_W   = 24;
   localparam int STATUS_W  = 2;
   localparam int GOFF_W    = 20;
   localparam int BYTES_W   = 13;
   localparam int COUNT_W   = 9;
   localparam int SPAN_W    = 21;
   localparam int ALU_W     = 24;
   localparam int STEP_W    = 5;
   localparam int MUL_STEPS = 9;
   localparam int REM_STEPS = 24;
   localparam int LINK_MAX  = 256;

   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CHECK = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

   localparam logic CSR_SLOT_BYTES   = 1'b0;
   localparam logic CSR_SLOTS_IN_USE = 1'b1;

   localparam logic [BYTES_W-1:0] BYTES_MIN   = 13'd8;
   localparam logic [BYTES_W-1:0] BYTES_MAX   = 13'd4096;
   localparam logic [BYTES_W-1:0] BYTES_RESET = 13'd16;
   localparam logic [COUNT_W-1:0] SLOTS_RESET = 9'd256;

   typedef enum logic {
      ALU_MUL,
      ALU_REM
   } alu_op_type;

   typedef struct packed {
      logic                start;
      alu_op_type          op;
      logic [ALU_W-1:0]    a;
      logic [BYTES_W-1:0]  b;
   } alu_cmd_type;

   typedef struct packed {
      logic                done;
      logic [ALU_W-1:0]    result;
   } alu_rsp_type;

endpackage

>>> rtl/fpfl_alu.sv
module fpfl_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  fpfl_pkg::alu_cmd_type cmd,
   output fpfl_pkg::alu_rsp_type rsp
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   fpfl_pkg::alu_op_type             op_ff, op_in;
   logic [fpfl_pkg::STEP_W-1:0]      cnt_ff, cnt_in;
   logic [fpfl_pkg::ALU_W-1:0]       acc_ff, acc_in;
   logic [fpfl_pkg::ALU_W-1:0]       sh_ff, sh_in;
   logic [fpfl_pkg::ALU_W-1:0]       mc_ff, mc_in;
   logic [fpfl_pkg::BYTES_W-1:0]     b_ff, b_in;

   logic [fpfl_pkg::BYTES_W:0]       trial;
   logic [fpfl_pkg::ALU_W-1:0]       add_x;
   logic [fpfl_pkg::ALU_W-1:0]       add_y;
   logic                             add_cin;
   logic [fpfl_pkg::ALU_W:0]         sum;
   logic                             last;

   // one shared adder: shift-add multiply or restoring remainder
   always_comb begin
      trial   = {acc_ff[fpfl_pkg::BYTES_W-1:0], sh_ff[fpfl_pkg::ALU_W-1]};
      add_cin = (op_ff == fpfl_pkg::ALU_REM);
      if (op_ff == fpfl_pkg::ALU_MUL) begin
         add_x = acc_ff;
         add_y = mc_ff;
      end else begin
         add_x = fpfl_pkg::ALU_W'(trial);
         add_y = ~(fpfl_pkg::ALU_W'(b_ff));
      end
      sum  = {1'b0, add_x} + {1'b0, add_y} + (fpfl_pkg::ALU_W + 1)'(add_cin);
      last = (op_ff == fpfl_pkg::ALU_MUL)
           ? (cnt_ff == fpfl_pkg::STEP_W'(fpfl_pkg::MUL_STEPS - 1))
           : (cnt_ff == fpfl_pkg::STEP_W'(fpfl_pkg::REM_STEPS - 1));
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      mc_in   = mc_ff;
      b_in    = b_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = '0;
         acc_in  = '0;
         sh_in   = cmd.a;
         mc_in   = fpfl_pkg::ALU_W'(cmd.b);
         b_in    = cmd.b;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (op_ff == fpfl_pkg::ALU_MUL) begin
            acc_in = sh_ff[0] ? sum[fpfl_pkg::ALU_W-1:0] : acc_ff;
            mc_in  = mc_ff << 1;
            sh_in  = sh_ff >> 1;
         end else begin
            acc_in = sum[fpfl_pkg::ALU_W] ? sum[fpfl_pkg::ALU_W-1:0]
                                          : fpfl_pkg::ALU_W'(trial);
            sh_in  = sh_ff << 1;
         end
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= fpfl_pkg::ALU_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      mc_ff  <= mc_in;
      b_ff   <= b_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff;

endmodule

>>> rtl/fixed_pool_free_list_allocator_top.sv
// channel  | dir | tvalid/tready        | tdata / tuser (lsb first)
// req      | in  | req_tvalid/tready    | tdata: slot_index, probe_offset; tuser: kind
// rsp      | out | rsp_tvalid/tready    | tdata: status, granted_index, granted_offset,
//          |     |                      |        offset_valid, zero pad
// csr      | in  | csr_we               | csr_addr, csr_wdata
// one transaction at a time; req_tready is high only while the sequencer is idle
// allocate: watermark or list pop (link read), then multiply; straight to done if exhausted
// free, reset: straight to done; check: 9-step span multiply, then 24-step remainder
// one shared shift-add/subtract unit does all of these; rsp is a held output register
// synchronous active-high reset; link memory holds no reset and needs no clearing pass
// a stalled rsp holds the finished result while the next request is already taken
`include "assert_macros.svh"

module fixed_pool_free_list_allocator_top #(
   parameter int POOL_SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // slot_index[7:0], probe_offset[31:8]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // status[1:0], granted_index[9:2],
                                    // granted_offset[29:10], offset_valid[30], pad[31]
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [12:0] csr_wdata
);

   localparam int LIM   = (POOL_SLOTS < fpfl_pkg::LINK_MAX) ? POOL_SLOTS : fpfl_pkg::LINK_MAX;
   localparam int IDX_W = $clog2(LIM);

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_MUL_WAIT,
      S_SPAN_WAIT,
      S_REM_WAIT,
      S_DONE
   } state_type;

   state_type                          state_ff, state_in;
   logic [fpfl_pkg::KIND_W-1:0]        kind_ff, kind_in;
   logic [fpfl_pkg::PROBE_W-1:0]       probe_ff, probe_in;
   logic [IDX_W-1:0]                   head_ff, head_in;
   logic                               nonempty_ff, nonempty_in;
   logic [fpfl_pkg::COUNT_W-1:0]       wm_ff, wm_in;
   logic [fpfl_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic [fpfl_pkg::INDEX_W-1:0]       gidx_ff, gidx_in;
   logic [fpfl_pkg::GOFF_W-1:0]        goff_ff, goff_in;
   logic                               valid_ff, valid_in;
   logic [fpfl_pkg::SPAN_W-1:0]        span_ff, span_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [31:0]                        rsp_data_ff, rsp_data_in;
   logic [fpfl_pkg::BYTES_W-1:0]       slot_bytes_ff, slot_bytes_in;
   logic [fpfl_pkg::COUNT_W-1:0]       slots_in_use_ff, slots_in_use_in;
   fpfl_pkg::alu_cmd_type              alu_cmd_ff, alu_cmd_in;
   fpfl_pkg::alu_rsp_type              alu_rsp;

   logic [IDX_W:0]                     link_mem [LIM];
   logic [IDX_W:0]                     rd_word_ff;
   logic                               mem_we;
   logic [IDX_W-1:0]                   mem_addr;

   logic [fpfl_pkg::BYTES_W-1:0]       bytes_eff;
   logic [fpfl_pkg::COUNT_W-1:0]       n_eff;
   logic [fpfl_pkg::INDEX_W-1:0]       req_index;
   logic [fpfl_pkg::PROBE_W-1:0]       req_probe;
   logic                               req_fire;
   logic                               idx_ok;
   logic                               alu_wait;
   logic                               pop_ok;

   fpfl_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd_ff),
      .rsp   (alu_rsp)
   );

   assign req_index  = req_tdata[7:0];
   assign req_probe  = req_tdata[31:8];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      priority if (slot_bytes_ff < fpfl_pkg::BYTES_MIN) begin
         bytes_eff = fpfl_pkg::BYTES_MIN;
      end else if (slot_bytes_ff > fpfl_pkg::BYTES_MAX) begin
         bytes_eff = fpfl_pkg::BYTES_MAX;
      end else begin
         bytes_eff = slot_bytes_ff;
      end
      n_eff  = (slots_in_use_ff > fpfl_pkg::COUNT_W'(LIM)) ? fpfl_pkg::COUNT_W'(LIM)
                                                            : slots_in_use_ff;
      idx_ok = ({1'b0, req_index} < n_eff);
   end

   assign mem_we   = req_fire && (req_tuser == fpfl_pkg::KIND_FREE) && idx_ok;
   assign mem_addr = req_index[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_addr] <= {~nonempty_ff, head_ff};
      end
      rd_word_ff <= link_mem[head_ff];
   end

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      probe_in        = probe_ff;
      head_in         = head_ff;
      nonempty_in     = nonempty_ff;
      wm_in           = wm_ff;
      status_in       = status_ff;
      gidx_in         = gidx_ff;
      goff_in         = goff_ff;
      valid_in        = valid_ff;
      span_in         = span_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      slot_bytes_in   = slot_bytes_ff;
      slots_in_use_in = slots_in_use_ff;
      alu_cmd_in      = alu_cmd_ff;
      alu_cmd_in.start = 1'b0;

      if (csr_we) begin
         unique case (csr_addr)
            fpfl_pkg::CSR_SLOT_BYTES:   slot_bytes_in   = csr_wdata;
            fpfl_pkg::CSR_SLOTS_IN_USE: slots_in_use_in = csr_wdata[fpfl_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               probe_in  = req_probe;
               status_in = fpfl_pkg::STATUS_OK;
               gidx_in   = '0;
               goff_in   = '0;
               valid_in  = 1'b0;
               unique case (req_tuser)
                  fpfl_pkg::KIND_ALLOC: begin
                     if (nonempty_ff) begin
                        state_in = S_POP;
                     end else if (wm_ff < n_eff) begin
                        gidx_in          = wm_ff[fpfl_pkg::INDEX_W-1:0];
                        wm_in            = wm_ff + 1'b1;
                        alu_cmd_in.start = 1'b1;
                        alu_cmd_in.op    = fpfl_pkg::ALU_MUL;
                        alu_cmd_in.a     = fpfl_pkg::ALU_W'(wm_ff);
                        alu_cmd_in.b     = bytes_eff;
                        state_in         = S_MUL_WAIT;
                     end else begin
                        status_in = fpfl_pkg::STATUS_EXHAUSTED;
                        state_in  = S_DONE;
                     end
                  end
                  fpfl_pkg::KIND_FREE: begin
                     if (idx_ok) begin
                        head_in     = req_index[IDX_W-1:0];
                        nonempty_in = 1'b1;
                     end else begin
                        status_in = fpfl_pkg::STATUS_RANGE;
                     end
                     state_in = S_DONE;
                  end
                  fpfl_pkg::KIND_RESET: begin
                     head_in     = '0;
                     nonempty_in = 1'b0;
                     wm_in       = '0;
                     state_in    = S_DONE;
                  end
                  fpfl_pkg::KIND_CHECK: begin
                     alu_cmd_in.start = 1'b1;
                     alu_cmd_in.op    = fpfl_pkg::ALU_MUL;
                     alu_cmd_in.a     = fpfl_pkg::ALU_W'(n_eff);
                     alu_cmd_in.b     = bytes_eff;
                     state_in         = S_SPAN_WAIT;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_POP: begin
            gidx_in = fpfl_pkg::INDEX_W'(head_ff);
            if (rd_word_ff[IDX_W]) begin
               nonempty_in = 1'b0;
            end else begin
               head_in = rd_word_ff[IDX_W-1:0];
            end
            alu_cmd_in.start = 1'b1;
            alu_cmd_in.op    = fpfl_pkg::ALU_MUL;
            alu_cmd_in.a     = fpfl_pkg::ALU_W'(head_ff);
            alu_cmd_in.b     = bytes_eff;
            state_in         = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (alu_rsp.done) begin
               goff_in  = alu_rsp.result[fpfl_pkg::GOFF_W-1:0];
               state_in = S_DONE;
            end
         end
         S_SPAN_WAIT: begin
            if (alu_rsp.done) begin
               span_in          = alu_rsp.result[fpfl_pkg::SPAN_W-1:0];
               alu_cmd_in.start = 1'b1;
               alu_cmd_in.op    = fpfl_pkg::ALU_REM;
               alu_cmd_in.a     = probe_ff;
               alu_cmd_in.b     = bytes_eff;
               state_in         = S_REM_WAIT;
            end
         end
         S_REM_WAIT: begin
            if (alu_rsp.done) begin
               valid_in = (probe_ff < fpfl_pkg::PROBE_W'(span_ff)) && (alu_rsp.result == '0);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, valid_ff, goff_ff, gidx_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         head_ff          <= '0;
         nonempty_ff      <= 1'b0;
         wm_ff            <= '0;
         rsp_valid_ff     <= 1'b0;
         slot_bytes_ff    <= fpfl_pkg::BYTES_RESET;
         slots_in_use_ff  <= fpfl_pkg::SLOTS_RESET;
         alu_cmd_ff.start <= 1'b0;
      end else begin
         state_ff         <= state_in;
         head_ff          <= head_in;
         nonempty_ff      <= nonempty_in;
         wm_ff            <= wm_in;
         rsp_valid_ff     <= rsp_valid_in;
         slot_bytes_ff    <= slot_bytes_in;
         slots_in_use_ff  <= slots_in_use_in;
         alu_cmd_ff.start <= alu_cmd_in.start;
      end
      kind_ff         <= kind_in;
      probe_ff        <= probe_in;
      status_ff       <= status_in;
      gidx_ff         <= gidx_in;
      goff_ff         <= goff_in;
      valid_ff        <= valid_in;
      span_ff         <= span_in;
      rsp_data_ff     <= rsp_data_in;
      alu_cmd_ff.op   <= alu_cmd_in.op;
      alu_cmd_ff.a    <= alu_cmd_in.a;
      alu_cmd_ff.b    <= alu_cmd_in.b;
   end

   assign alu_wait = (state_ff == S_MUL_WAIT) || (state_ff == S_SPAN_WAIT) ||
                     (state_ff == S_REM_WAIT);
   assign pop_ok   = (kind_ff == fpfl_pkg::KIND_ALLOC) && nonempty_ff;

   `FPFL_ASSERT(a_wm_bound, (wm_ff <= fpfl_pkg::COUNT_W'(LIM)), "watermark past pool depth")
   `FPFL_ASSERT(a_done_in_wait, alu_rsp.done |-> alu_wait, "alu done outside wait")
   `FPFL_ASSERT(a_busy_after_fire, req_fire |=> !req_tready, "ready right after a taken request")
   `FPFL_ASSERT(a_pop_kind, (state_ff == S_POP) |-> pop_ok, "pop without allocate")

endmodule
